### sv/drl_pkg.sv
// Shared package for the dark run line detector.
// Holds field widths, register reset values, register indexes and the event flag type.
// No dependencies.
`default_nettype none

package drl_pkg;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int LEN_W      = 13;
    localparam int LINE_IDX_W = 12;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Limits and default sizes
    localparam int MAX_LINE_LENGTH    = 4096;
    localparam int MAX_SCAN_LINES_DEF = 4096;
    localparam int QUEUE_DEPTH_DEF    = 4;

    // Register reset values
    localparam logic [LEN_W-1:0] LINE_LENGTH_RST = 13'd1024;
    localparam logic [PIX_W-1:0] DARK_LIMIT_RST  = 8'd240;
    localparam logic [LEN_W-1:0] MIN_LENGTH_RST  = 13'd50;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_LENGTH = 2'd0,
        CFG_DARK_LIMIT  = 2'd1,
        CFG_MIN_LENGTH  = 2'd2
    } t_cfg_reg;

    // Flags of one event passed from the front to the back
    typedef struct packed {
        logic frame_start;
        logic segment;
    } t_ev_flags;

    localparam int EV_FLAGS_W = $bits(t_ev_flags);

endpackage

`default_nettype wire

### sv/drl_pix_if.sv
// Pixel request channel: valid/ready handshake with pixel and frame start.
// Depends on drl_pkg.
`default_nettype none

interface drl_pix_if;
    import drl_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

`default_nettype wire

### sv/drl_seg_if.sv
// Segment request channel: valid/ready handshake with line index, end position, run length.
// Depends on drl_pkg.
`default_nettype none

interface drl_seg_if;
    import drl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [LINE_IDX_W-1:0] line_index;
    logic [LEN_W-1:0]      end_pos;
    logic [LEN_W-1:0]      run_length;

    modport source (output valid, output line_index, output end_pos, output run_length,
                    input ready);
    modport sink   (input valid, input line_index, input end_pos, input run_length,
                    output ready);
endinterface

`default_nettype wire

### sv/drl_front.sv
// Front end: configuration registers, pixel acceptance, run tracking and segment candidates.
// Depends on drl_pkg and drl_pix_if.
`default_nettype none

module drl_front #(
    parameter int MAX_SCAN_LINES = drl_pkg::MAX_SCAN_LINES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [drl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [drl_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    drl_pix_if.sink                                  i_pix,
    input  wire logic                                i_full,
    output logic                                     o_push,
    output drl_pkg::t_ev_flags                       o_flags,
    output logic [$clog2(MAX_SCAN_LINES)-1:0]        o_line,
    output logic [drl_pkg::LEN_W-1:0]                o_end,
    output logic [drl_pkg::LEN_W-1:0]                o_len
);
    import drl_pkg::*;

    localparam int                SCAN_W     = $clog2(MAX_SCAN_LINES);
    localparam logic [LEN_W-1:0]  MAX_LEN    = LEN_W'(MAX_LINE_LENGTH);
    localparam logic [SCAN_W:0]   SCAN_LIMIT = (SCAN_W+1)'(MAX_SCAN_LINES);

    logic [LEN_W-1:0]  r_line_length;
    logic [PIX_W-1:0]  r_dark_limit;
    logic [LEN_W-1:0]  r_min_length;

    logic [LEN_W-1:0]  r_position, n_position;
    logic [SCAN_W-1:0] r_scan_line, n_scan_line;
    logic [LEN_W-1:0]  r_run_count, n_run_count;
    logic              r_in_run, n_in_run;

    logic              accept;
    logic              fs;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  pos0, run0, run1, pos_inc;
    logic [SCAN_W-1:0] line0;
    logic [SCAN_W:0]   line_inc;
    logic              in0, in1, dark, eol, seg_light, seg_eol;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LINE_LENGTH_RST;
            r_dark_limit  <= DARK_LIMIT_RST;
            r_min_length  <= MIN_LENGTH_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LINE_LENGTH: r_line_length <= i_cfg_data[LEN_W-1:0];
                CFG_DARK_LIMIT:  r_dark_limit  <= i_cfg_data[PIX_W-1:0];
                CFG_MIN_LENGTH:  r_min_length  <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Take a pixel whenever the queue has room
    assign i_pix.ready = !i_full;
    assign accept      = i_pix.valid && !i_full;
    assign fs          = i_pix.frame_start;

    // Clamp the line length to the legal range
    always_comb begin
        eff_len = r_line_length;
        if (r_line_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_line_length > MAX_LEN) begin
            eff_len = MAX_LEN;
        end
    end

    // Classify the pixel and compute the next run state
    always_comb begin
        pos0  = fs ? '0 : r_position;
        run0  = fs ? '0 : r_run_count;
        in0   = fs ? 1'b0 : r_in_run;
        line0 = fs ? '0 : r_scan_line;

        dark = i_pix.pixel < r_dark_limit;
        if (dark) begin
            run1      = run0 + 1'b1;
            in1       = 1'b1;
            seg_light = 1'b0;
        end else begin
            run1      = '0;
            in1       = 1'b0;
            seg_light = in0 && (run0 > r_min_length);
        end

        pos_inc  = pos0 + 1'b1;
        eol      = pos_inc >= eff_len;
        seg_eol  = eol && in1 && (run1 > r_min_length);
        line_inc = {1'b0, line0} + 1'b1;

        if (eol) begin
            n_position  = '0;
            n_run_count = '0;
            n_in_run    = 1'b0;
            n_scan_line = (line_inc >= SCAN_LIMIT) ? '0 : line_inc[SCAN_W-1:0];
        end else begin
            n_position  = pos_inc;
            n_run_count = run1;
            n_in_run    = in1;
            n_scan_line = line0;
        end
    end

    // Advance the run state on each accepted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= '0;
            r_scan_line <= '0;
            r_run_count <= '0;
            r_in_run    <= 1'b0;
        end else if (accept) begin
            r_position  <= n_position;
            r_scan_line <= n_scan_line;
            r_run_count <= n_run_count;
            r_in_run    <= n_in_run;
        end
    end

    // Queue a candidate segment or a frame start marker
    assign o_push  = accept && (seg_light || seg_eol || fs);
    assign o_flags = '{frame_start: fs, segment: seg_light || seg_eol};
    assign o_line  = line0;
    assign o_end   = seg_light ? pos0 : eff_len;
    assign o_len   = seg_light ? run0 : run1;

endmodule

`default_nettype wire

### sv/drl_fifo.sv
// Small event queue between the front and the back, first in first out.
// No dependencies.
`default_nettype none

module drl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty,
    output logic                  o_full
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    // Store a pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Step pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = r_count == '0;
    assign o_full  = r_count == CW'(DEPTH);

endmodule

`default_nettype wire

### sv/drl_back.sv
// Back end: filters segment candidates against the previous segment line and
// holds the result in an output register. Depends on drl_pkg and drl_seg_if.
`default_nettype none

module drl_back #(
    parameter int MAX_SCAN_LINES = drl_pkg::MAX_SCAN_LINES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_empty,
    input  wire drl_pkg::t_ev_flags                  i_flags,
    input  wire logic [$clog2(MAX_SCAN_LINES)-1:0]   i_line,
    input  wire logic [drl_pkg::LEN_W-1:0]           i_end,
    input  wire logic [drl_pkg::LEN_W-1:0]           i_len,
    output logic                                     o_pop,
    drl_seg_if.source                                o_seg
);
    import drl_pkg::*;

    localparam int SCAN_W = $clog2(MAX_SCAN_LINES);

    logic                  r_have_prev, n_have_prev;
    logic [SCAN_W-1:0]     r_prev_line, n_prev_line;
    logic                  r_out_valid, n_out_valid;
    logic [LINE_IDX_W-1:0] r_out_line;
    logic [LEN_W-1:0]      r_out_end;
    logic [LEN_W-1:0]      r_out_len;

    logic                  can_load;
    logic                  have_prev;
    logic                  report;
    logic                  load;
    logic [SCAN_W:0]       prev_inc;
    logic [31:0]           line_wide;

    // Decide whether the head event gives a result
    always_comb begin
        can_load  = !r_out_valid || o_seg.ready;
        o_pop     = !i_empty && can_load;
        have_prev = i_flags.frame_start ? 1'b0 : r_have_prev;
        prev_inc  = {1'b0, r_prev_line} + 1'b1;
        report    = !have_prev || ({1'b0, i_line} > prev_inc);
        load      = o_pop && i_flags.segment && report;
        line_wide = 32'(i_line);

        n_have_prev = r_have_prev;
        n_prev_line = r_prev_line;
        if (o_pop) begin
            if (i_flags.segment) begin
                n_have_prev = 1'b1;
                n_prev_line = i_line;
            end else if (i_flags.frame_start) begin
                n_have_prev = 1'b0;
            end
        end

        if (load) begin
            n_out_valid = 1'b1;
        end else if (o_seg.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Hold the filter state and the output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev_line <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_have_prev <= n_have_prev;
            r_prev_line <= n_prev_line;
            r_out_valid <= n_out_valid;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_line <= line_wide[LINE_IDX_W-1:0];
            r_out_end  <= i_end;
            r_out_len  <= i_len;
        end
    end

    assign o_seg.valid      = r_out_valid;
    assign o_seg.line_index = r_out_line;
    assign o_seg.end_pos    = r_out_end;
    assign o_seg.run_length = r_out_len;

endmodule

`default_nettype wire

### sv/dark_run_line_detector_unit.sv
// Top level of the dark run line detector: front end, event queue and back end.
// Depends on drl_pkg, drl_pix_if, drl_seg_if, drl_front, drl_fifo and drl_back.
//
// The unit takes one pixel per clock while the event queue has room, and
// reports at most one line segment per pixel. The edge that takes the pixel
// that closes a segment writes its event into the event queue; from there it
// is loaded into the back end's output register when that is free. The pixel
// ready drops only when the event queue (QUEUE_DEPTH entries, frame starts and
// segment candidates) is full behind a stalled output. There is no clearing
// pass after reset; pixels are taken from the first clock out of reset.
// Configuration registers: index 0 line length, 1 dark limit, 2 minimum length;
// write them only while no pixel is in flight.
`default_nettype none

module dark_run_line_detector_unit #(
    parameter int MAX_SCAN_LINES = drl_pkg::MAX_SCAN_LINES_DEF,
    parameter int QUEUE_DEPTH    = drl_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [drl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [drl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    drl_pix_if.sink                             i_pix,
    drl_seg_if.source                           o_seg
);
    import drl_pkg::*;

    localparam int SCAN_W = $clog2(MAX_SCAN_LINES);
    localparam int Q_W    = EV_FLAGS_W + SCAN_W + 2 * LEN_W;

    logic              push, pop, q_empty, q_full;
    t_ev_flags         f_flags, b_flags;
    logic [SCAN_W-1:0] f_line, b_line;
    logic [LEN_W-1:0]  f_end, b_end, f_len, b_len;
    logic [Q_W-1:0]    q_in, q_out;

    drl_front #(
        .MAX_SCAN_LINES(MAX_SCAN_LINES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (i_pix),
        .i_full      (q_full),
        .o_push      (push),
        .o_flags     (f_flags),
        .o_line      (f_line),
        .o_end       (f_end),
        .o_len       (f_len)
    );

    // Pack and unpack queue entries
    assign q_in = {f_flags, f_line, f_end, f_len};
    assign b_flags = t_ev_flags'(q_out[Q_W-1 -: EV_FLAGS_W]);
    assign b_line  = q_out[2*LEN_W +: SCAN_W];
    assign b_end   = q_out[LEN_W +: LEN_W];
    assign b_len   = q_out[0 +: LEN_W];

    drl_fifo #(
        .WIDTH(Q_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    drl_back #(
        .MAX_SCAN_LINES(MAX_SCAN_LINES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_flags (b_flags),
        .i_line  (b_line),
        .i_end   (b_end),
        .i_len   (b_len),
        .o_pop   (pop),
        .o_seg   (o_seg)
    );

endmodule

`default_nettype wire

### sv/drl_checker.sv
// Port checker for the dark run line detector, bound to the top level.
// Depends on drl_pkg and dark_run_line_detector_unit.
`default_nettype none

module drl_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_valid,
    input wire logic                           i_ready,
    input wire logic [drl_pkg::LINE_IDX_W-1:0] i_line_index,
    input wire logic [drl_pkg::LEN_W-1:0]      i_end_pos,
    input wire logic [drl_pkg::LEN_W-1:0]      i_run_length
);
    import drl_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LINE_LENGTH);

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk) $past(!i_rst_n) |-> !i_valid)
        else $error("segment valid right after reset");

    // Hold a stalled result
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("segment dropped while stalled");

    // Keep a stalled payload stable
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_line_index) && $stable(i_end_pos)
                                && $stable(i_run_length))
        else $error("segment payload changed while stalled");

    // A reported run is nonempty and fits in a line
    a_run_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_run_length != '0 && i_run_length <= MAX_LEN
                    && i_end_pos != '0 && i_end_pos <= MAX_LEN)
        else $error("segment length or end out of range");

endmodule

bind dark_run_line_detector_unit drl_checker u_drl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_seg.valid),
    .i_ready      (o_seg.ready),
    .i_line_index (o_seg.line_index),
    .i_end_pos    (o_seg.end_pos),
    .i_run_length (o_seg.run_length)
);

`default_nettype wire

### tb/tb_dark_run_line_detector_unit.sv
// Self-checking testbench for dark_run_line_detector_unit: random pixel frames
// against a cycle-free predictor of the run detector, with random stalls on both sides.
// Depends on drl_pkg, drl_pix_if, drl_seg_if and the detector RTL.

module tb_dark_run_line_detector_unit;
    import drl_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 6;
    localparam int SETTLE_CYCLES    = 6;
    localparam int DRAIN_CYCLES     = 10;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int REPORT_LIMIT     = 10;

    // Hand-picked opening pixels; frame starts sit at the first and the 21st pixel
    localparam logic [PIX_W-1:0] DIRECTED_PIXELS [23] = '{
        8'd0,   8'd99,  8'd100, 8'd255, 8'd50,  8'd60,
        8'd200, 8'd250, 8'd255, 8'd128, 8'd101, 8'd255,
        8'd1,   8'd2,   8'd3,   8'd255, 8'd0,   8'd254,
        8'd9,   8'd8,   8'd7,   8'd6,   8'd255
    };

    typedef enum {LINE_LIGHT, LINE_DARK, LINE_RUNS} t_line_mode;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_pixel_req;

    typedef struct packed {
        logic [LINE_IDX_W-1:0] line_index;
        logic [LEN_W-1:0]      end_pos;
        logic [LEN_W-1:0]      run_length;
    } t_segment;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    drl_pix_if pixel_ch ();
    drl_seg_if segment_ch ();

    dark_run_line_detector_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pixel_ch.sink),
        .o_seg       (segment_ch.source)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow registers and detector state of the predictor
    logic [LEN_W-1:0] shadow_line_length;
    logic [PIX_W-1:0] shadow_dark_limit;
    logic [LEN_W-1:0] shadow_min_length;
    int               pos_in_line;
    int               line_count;
    int               dark_run;
    bit               run_open;
    bit               seen_segment;
    int               last_segment_line;

    t_pixel_req pixel_requests[$];
    t_segment   pending_segments[$];
    t_pixel_req next_request;
    t_segment   predicted;
    t_segment   observed;
    t_segment   wanted;

    int send_idle_pct;
    int stall_pct;
    int send_gap;
    int stall_gap;
    int holds_requested;
    int holds_served;
    int long_hold_left;
    int cycle_count;
    int error_count;
    int pixels_accepted;
    int segments_checked;
    int input_stall_cycles;
    int setting_count;

    // Close a dark run; report it unless it sits on the same line as the last one or the line right after
    function automatic bit close_segment(input int end_at, output t_segment seg);
        bit report;
        report = !seen_segment || (line_count > last_segment_line + 1);
        seen_segment = 1'b1;
        last_segment_line = line_count;
        seg.line_index = line_count[LINE_IDX_W-1:0];
        seg.end_pos = end_at[LEN_W-1:0];
        seg.run_length = dark_run[LEN_W-1:0];
        return report;
    endfunction

    // Advance the detector by one pixel; returns 1 when a segment is reported
    function automatic bit scan_pixel(input t_pixel_req req, output t_segment seg);
        int span;
        bit found;
        if (shadow_line_length == 0)
            span = 1;
        else if (shadow_line_length > MAX_LINE_LENGTH)
            span = MAX_LINE_LENGTH;
        else
            span = int'(shadow_line_length);
        found = 1'b0;
        seg = '0;
        if (req.frame_start) begin
            pos_in_line = 0;
            line_count = 0;
            dark_run = 0;
            run_open = 1'b0;
            seen_segment = 1'b0;
            last_segment_line = 0;
        end
        if (req.pixel < shadow_dark_limit) begin
            dark_run++;
            run_open = 1'b1;
        end else begin
            if (run_open && dark_run > shadow_min_length)
                found = close_segment(pos_in_line, seg);
            run_open = 1'b0;
            dark_run = 0;
        end
        pos_in_line++;
        // End of scan line, also when the line was shortened below the position
        if (pos_in_line >= span) begin
            if (run_open && dark_run > shadow_min_length)
                found = close_segment(span, seg);
            run_open = 1'b0;
            dark_run = 0;
            pos_in_line = 0;
            line_count++;
            if (line_count >= MAX_SCAN_LINES_DEF)
                line_count = 0;
        end
        return found;
    endfunction

    task automatic note_error(input string field, input int unsigned want, input int unsigned got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("[%0d] segment %0d: %s expected %0d, got %0d",
                     cycle_count, segments_checked, field, want, got);
    endtask

    // Pixel driver: hold the request until taken, insert idle bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pixel_ch.valid <= 1'b0;
            send_gap <= 0;
        end else if (!pixel_ch.valid || pixel_ch.ready) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                pixel_ch.valid <= 1'b0;
            end else if (pixel_requests.size() != 0 && $urandom_range(99) < send_idle_pct) begin
                send_gap <= $urandom_range(6, 0);
                pixel_ch.valid <= 1'b0;
            end else if (pixel_requests.size() != 0) begin
                next_request = pixel_requests.pop_front();
                pixel_ch.valid <= 1'b1;
                pixel_ch.pixel <= next_request.pixel;
                pixel_ch.frame_start <= next_request.frame_start;
            end else begin
                pixel_ch.valid <= 1'b0;
            end
        end
    end

    // Segment receiver: random stall bursts, long hold when one is pending
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            segment_ch.ready <= 1'b0;
            stall_gap <= 0;
        end else if (long_hold_left != 0) begin
            segment_ch.ready <= 1'b0;
        end else if (stall_gap != 0) begin
            stall_gap <= stall_gap - 1;
            segment_ch.ready <= 1'b0;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_gap <= $urandom_range(6, 0);
            segment_ch.ready <= 1'b0;
        end else begin
            segment_ch.ready <= 1'b1;
        end
    end

    // Count out a long receiver hold each time one is requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            long_hold_left <= 0;
            holds_served <= 0;
        end else if (long_hold_left != 0) begin
            long_hold_left <= long_hold_left - 1;
        end else if (holds_served != holds_requested) begin
            long_hold_left <= LONG_HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
    end

    // Monitor: predict on accepted pixels, check accepted segments in order
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pixel_ch.valid && pixel_ch.ready) begin
                pixels_accepted++;
                if (scan_pixel('{pixel: pixel_ch.pixel, frame_start: pixel_ch.frame_start},
                               predicted))
                    pending_segments.insert(pending_segments.size(), predicted);
            end
            if (pixel_ch.valid && !pixel_ch.ready)
                input_stall_cycles++;
            if (segment_ch.valid && segment_ch.ready) begin
                observed = '{line_index: segment_ch.line_index, end_pos: segment_ch.end_pos,
                             run_length: segment_ch.run_length};
                if (pending_segments.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("[%0d] unexpected segment: line %0d end %0d run %0d",
                                 cycle_count, observed.line_index, observed.end_pos,
                                 observed.run_length);
                end else begin
                    wanted = pending_segments.pop_front();
                    if (observed.line_index != wanted.line_index)
                        note_error("line_index", wanted.line_index, observed.line_index);
                    if (observed.end_pos != wanted.end_pos)
                        note_error("end_pos", wanted.end_pos, observed.end_pos);
                    if (observed.run_length != wanted.run_length)
                        note_error("run_length", wanted.run_length, observed.run_length);
                    segments_checked++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d segments still expected",
                     cycle_count, pending_segments.size());
            $display("** dark_run_line_detector_unit: FAILED **");
            $finish;
        end
    end

    task automatic queue_pixel(input logic [PIX_W-1:0] value, input logic start);
        t_pixel_req req;
        req.pixel = value;
        req.frame_start = start;
        pixel_requests.insert(pixel_requests.size(), req);
    endtask

    // Wait until every pixel is taken and every segment is back, then let the pipe drain
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pixel_requests.size() != 0 || pixel_ch.valid || pending_segments.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_reg index, input int value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        case (index)
            CFG_LINE_LENGTH: shadow_line_length = value[LEN_W-1:0];
            CFG_DARK_LIMIT:  shadow_dark_limit = value[PIX_W-1:0];
            CFG_MIN_LENGTH:  shadow_min_length = value[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // Build frames of scan lines: all light, all dark, or dark runs in light,
    // with stray bytes and stray frame starts as noise
    task automatic queue_pixels(input int count, input bit open_frame, input int frame_lines,
                                input int dark_line_pct);
        int         span;
        int         left;
        int         lines;
        int         pos;
        bit         start_pending;
        bit         dark_now;
        t_line_mode mode;
        logic [PIX_W-1:0] value;
        @(negedge i_clk);
        span = (shadow_line_length == 0) ? 1 :
               (shadow_line_length > MAX_LINE_LENGTH) ? MAX_LINE_LENGTH : int'(shadow_line_length);
        left = count;
        start_pending = open_frame;
        while (left > 0) begin
            lines = (frame_lines != 0) ? frame_lines : $urandom_range(10, 3);
            for (int l = 0; l < lines && left > 0; l++) begin
                if ($urandom_range(99) < dark_line_pct)
                    mode = LINE_DARK;
                else if ($urandom_range(99) < 30)
                    mode = LINE_LIGHT;
                else
                    mode = LINE_RUNS;
                dark_now = 1'($urandom_range(1, 0));
                for (pos = 0; pos < span && left > 0; pos++) begin
                    if (mode == LINE_RUNS && $urandom_range(9) == 0)
                        dark_now = !dark_now;
                    if ((mode == LINE_DARK || (mode == LINE_RUNS && dark_now))
                            && shadow_dark_limit != 0)
                        value = PIX_W'($urandom_range(shadow_dark_limit - 1, 0));
                    else
                        value = PIX_W'($urandom_range(255, shadow_dark_limit));
                    if ($urandom_range(99) < 3)
                        value = PIX_W'($urandom_range(255, 0));
                    queue_pixel(value, start_pending || $urandom_range(199) == 0);
                    start_pending = 1'b0;
                    left--;
                end
            end
            start_pending = 1'b1;
        end
    endtask

    // One setting: wait for idle, write all registers, then queue its pixels
    task automatic run_phase(input int line_len, input int dark, input int min_len,
                             input int count, input int idle_pct, input bit open_frame,
                             input int frame_lines, input int dark_line_pct);
        wait_idle();
        write_register(CFG_LINE_LENGTH, line_len);
        write_register(CFG_DARK_LIMIT, dark);
        write_register(CFG_MIN_LENGTH, min_len);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        send_idle_pct = idle_pct;
        stall_pct = idle_pct;
        setting_count++;
        queue_pixels(count, open_frame, frame_lines, dark_line_pct);
    endtask

    initial begin
        int len;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_LINE_LENGTH;
        i_cfg_data = '0;
        pixel_ch.valid = 1'b0;
        pixel_ch.pixel = '0;
        pixel_ch.frame_start = 1'b0;
        segment_ch.ready = 1'b0;
        shadow_line_length = LINE_LENGTH_RST;
        shadow_dark_limit = DARK_LIMIT_RST;
        shadow_min_length = MIN_LENGTH_RST;
        pos_in_line = 0;
        line_count = 0;
        dark_run = 0;
        run_open = 1'b0;
        seen_segment = 1'b0;
        last_segment_line = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        holds_requested = 0;
        cycle_count = 0;
        error_count = 0;
        pixels_accepted = 0;
        segments_checked = 0;
        input_stall_cycles = 0;
        setting_count = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: dark first pixel, runs ending at a light pixel and at line end,
        // a second segment on the same line suppressed, one two lines on reported,
        // and a frame start in the middle of a line
        run_phase(6, 100, 1, 0, 20, 1'b1, 0, 0);
        foreach (DIRECTED_PIXELS[i])
            queue_pixel(DIRECTED_PIXELS[i], i == 0 || i == 20);

        // Reset values, part of a long line
        run_phase(1024, 240, 50, 300, 20, 1'b1, 0, 30);
        // One pixel per line in a single frame
        run_phase(1, 255, 0, 150, 10, 1'b1, 5000, 15);
        // Zero line length with nothing dark and a minimum of 4096
        run_phase(0, 0, 4096, 40, 30, 1'b1, 0, 15);
        // Oversized line length with dark pixels and a large minimum
        run_phase(8191, 200, 4095, 100, 5, 1'b1, 0, 100);

        // Random settings; the third one sends short all-dark lines and holds
        // the receiver off while pixels keep coming
        for (int k = 0; k < 6; k++) begin
            len = (k == 2) ? 4 : $urandom_range(40, 2);
            run_phase(len, $urandom_range(255, 1), $urandom_range(len / 2, 0), 100,
                      (k == 2) ? 0 : $urandom_range(40, 0), 1'($urandom_range(1, 0)), 0,
                      (k == 2) ? 100 : 15);
            if (k == 2)
                holds_requested++;
        end

        // Stop mid-line, then shrink the line below the current position
        run_phase(40, 128, 2, 100, 20, 1'b1, 0, 15);
        run_phase(6, 128, 1, 100, 0, 1'b0, 0, 15);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_segments.size() != 0)
            $display("%0d expected segments never arrived", pending_segments.size());
        $display("covered %0d pixels over %0d register settings, %0d segments checked,",
                 pixels_accepted, setting_count, segments_checked);
        $display("%0d cycles with the pixel input held off, %0d errors",
                 input_stall_cycles, error_count);
        if (error_count == 0 && pending_segments.size() == 0)
            $display("** dark_run_line_detector_unit: PASSED **");
        else
            $display("** dark_run_line_detector_unit: FAILED **");
        $finish;
    end

endmodule

### dark_run_line_detector_unit.f
sv/drl_pkg.sv
sv/drl_pix_if.sv
sv/drl_seg_if.sv
sv/drl_front.sv
sv/drl_fifo.sv
sv/drl_back.sv
sv/dark_run_line_detector_unit.sv
sv/drl_checker.sv
tb/tb_dark_run_line_detector_unit.sv
